// ===== design/rtc_calendar_alarm_stopwatch_defines.svh =====
// Assertion macros used by the checker file of the clock block.
`ifndef RTC_CALENDAR_ALARM_STOPWATCH_DEFINES_SVH
`define RTC_CALENDAR_ALARM_STOPWATCH_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RTCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RTCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rtca_pkg.sv =====
// Types and codes shared by the clock, calendar, alarm and stopwatch block.
package rtca_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_INC      = 3'd1,
    ACT_DEC      = 3'd2,
    ACT_SW_RESET = 3'd3,
    ACT_SW_RUN   = 3'd4,
    ACT_SW_STOP  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    WM_STOP  = 2'd0,
    WM_RUN   = 2'd1,
    WM_RESET = 2'd2
  } watch_mode_e;

  typedef enum logic [1:0] {
    REG_ALARM_EN    = 2'd0,
    REG_DISP_MODE   = 2'd1,
    REG_EDIT_MODE   = 2'd2,
    REG_EDIT_TARGET = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TGT_ALARM_DATE = 2'd0,
    TGT_ALARM_TIME = 2'd1,
    TGT_DATE       = 2'd2,
    TGT_TIME       = 2'd3
  } edit_target_e;

  localparam logic [1:0] DISP_WATCH = 2'd0;
  localparam logic [1:0] DISP_TIME  = 2'd2;

  localparam logic [1:0] FLD_LOW  = 2'd1;  // seconds or days
  localparam logic [1:0] FLD_MID  = 2'd2;  // minutes or months
  localparam logic [1:0] FLD_HIGH = 2'd3;  // hours or years

  typedef struct packed {
    logic         alarm_en;
    logic [1:0]   display_mode;
    logic         edit_mode;
    edit_target_e edit_target;
  } cfg_t;

  typedef struct packed {
    logic [3:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic       alarm_hit;
  } res_t;

endpackage

// ===== design/rtca_cfg.sv =====
// Configuration register file of the clock block.
module rtca_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_i,
  input  logic [rtca_pkg::CFG_IDX_W-1:0]   index_i,
  input  logic [rtca_pkg::CFG_DATA_W-1:0]  data_i,
  output rtca_pkg::cfg_t                   cfg_o
);
  import rtca_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (cfg_reg_e'(index_i))
        REG_ALARM_EN:    cfg_d.alarm_en     = data_i[0];
        REG_DISP_MODE:   cfg_d.display_mode = data_i[1:0];
        REG_EDIT_MODE:   cfg_d.edit_mode    = data_i[0];
        REG_EDIT_TARGET: cfg_d.edit_target  = edit_target_e'(data_i[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_en     <= 1'b1;
      cfg_q.display_mode <= DISP_TIME;
      cfg_q.edit_mode    <= 1'b0;
      cfg_q.edit_target  <= TGT_DATE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/rtca_core.sv =====
// Clock, calendar, alarm and stopwatch state with the per-item update logic.
module rtca_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  rtca_pkg::action_e action_i,
  input  logic [1:0]        field_i,
  input  rtca_pkg::cfg_t    cfg_i,
  output rtca_pkg::res_t    res_o
);
  import rtca_pkg::*;

  typedef struct packed {
    logic [3:0] h;
    logic [5:0] m;
    logic [5:0] s;
  } hms_t;

  typedef struct packed {
    logic [4:0] d;
    logic [3:0] mo;
    logic [6:0] y;
  } date_t;

  function automatic logic [4:0] month_len(logic [3:0] mo, logic [6:0] yr);
    logic [4:0] len;
    if (mo == 4'd2) len = (yr[1:0] == 2'd0) ? 5'd29 : 5'd28;
    else if (mo inside {4'd4, 4'd6, 4'd9, 4'd11}) len = 5'd30;
    else len = 5'd31;
    return len;
  endfunction

  function automatic logic [6:0] step_wrap(logic [6:0] v, logic [6:0] lo, logic [6:0] hi,
                                           logic up);
    logic [6:0] r;
    if (up) r = (v >= hi) ? lo : v + 7'd1;
    else    r = (v <= lo) ? hi : v - 7'd1;
    return r;
  endfunction

  // True when one second from t the hour goes from 11 to 12.
  function automatic logic rolls(hms_t t);
    return (t.s >= 6'd59) && (t.m >= 6'd59) && (t.h == 4'd11);
  endfunction

  function automatic hms_t adv_time(hms_t t);
    hms_t r;
    r = t;
    if (t.s < 6'd59) begin
      r.s = t.s + 6'd1;
    end else begin
      r.s = '0;
      if (t.m < 6'd59) begin
        r.m = t.m + 6'd1;
      end else begin
        r.m = '0;
        if (t.h == 4'd11)      r.h = 4'd12;
        else if (t.h >= 4'd12) r.h = 4'd1;
        else                   r.h = t.h + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic date_t adv_date(date_t c);
    date_t r;
    r = c;
    if (c.d >= month_len(c.mo, c.y)) begin
      r.d = 5'd1;
      if (c.mo == 4'd12) begin
        r.mo = 4'd1;
        r.y  = (c.y >= 7'd99) ? 7'd0 : c.y + 7'd1;
      end else begin
        // out-of-range months count on and wrap through zero
        r.mo = c.mo + 4'd1;
      end
    end else begin
      r.d = c.d + 5'd1;
    end
    return r;
  endfunction

  function automatic hms_t hms_edit(hms_t t, logic [1:0] fld, logic up);
    hms_t r;
    r = t;
    case (fld)
      FLD_LOW:  r.s = 6'(step_wrap({1'b0, t.s}, 7'd0, 7'd59, up));
      FLD_MID:  r.m = 6'(step_wrap({1'b0, t.m}, 7'd0, 7'd59, up));
      FLD_HIGH: r.h = 4'(step_wrap({3'b0, t.h}, 7'd1, 7'd12, up));
      default: ;
    endcase
    return r;
  endfunction

  function automatic date_t cal_edit(date_t c, logic [1:0] fld, logic up);
    date_t r;
    r = c;
    case (fld)
      FLD_LOW:  r.d  = 5'(step_wrap({2'b0, c.d}, 7'd1, {2'b0, month_len(c.mo, c.y)}, up));
      FLD_MID:  r.mo = 4'(step_wrap({3'b0, c.mo}, 7'd1, 7'd12, up));
      FLD_HIGH: r.y  = step_wrap(c.y, 7'd0, 7'd99, up);
      default: ;
    endcase
    return r;
  endfunction

  hms_t        clk_q, clk_d;
  logic        pm_q, pm_d;
  date_t       cal_q, cal_d;
  hms_t        al_time_q, al_time_d;
  date_t       al_date_q, al_date_d;
  hms_t        sw_q, sw_d;
  watch_mode_e wm_q, wm_d;
  logic        hit;
  logic        up;
  logic        frozen;

  assign up     = (action_i == ACT_INC);
  assign frozen = cfg_i.edit_mode && (cfg_i.edit_target == TGT_TIME);

  always_comb begin
    clk_d     = clk_q;
    pm_d      = pm_q;
    cal_d     = cal_q;
    al_time_d = al_time_q;
    al_date_d = al_date_q;
    sw_d      = sw_q;
    hit       = 1'b0;
    if (step_i) begin
      case (action_i)
        ACT_TICK: begin
          if (!frozen) begin
            clk_d = adv_time(clk_q);
            if (rolls(clk_q)) begin
              if (pm_q) cal_d = adv_date(cal_q);
              pm_d = !pm_q;
            end
            hit = cfg_i.alarm_en && (al_date_q == cal_d) && (al_time_q == clk_d);
            if (cfg_i.display_mode == DISP_WATCH) begin
              case (wm_q)
                WM_RESET: sw_d = '0;
                WM_RUN:   sw_d = adv_time(sw_q);
                default: ;
              endcase
            end
          end
        end
        ACT_INC, ACT_DEC: begin
          if (cfg_i.edit_mode) begin
            case (cfg_i.edit_target)
              TGT_ALARM_DATE: al_date_d = cal_edit(al_date_q, field_i, up);
              TGT_ALARM_TIME: al_time_d = hms_edit(al_time_q, field_i, up);
              TGT_DATE:       cal_d     = cal_edit(cal_q, field_i, up);
              TGT_TIME:       clk_d     = hms_edit(clk_q, field_i, up);
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Stopwatch mode follows the stopwatch commands.
  always_comb begin
    wm_d = wm_q;
    if (step_i) begin
      case (action_i)
        ACT_SW_RESET: wm_d = WM_RESET;
        ACT_SW_RUN:   wm_d = WM_RUN;
        ACT_SW_STOP:  wm_d = WM_STOP;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_i.display_mode == DISP_WATCH) begin
      res_o.hour   = sw_d.h;
      res_o.minute = sw_d.m;
      res_o.second = sw_d.s;
    end else begin
      res_o.hour   = clk_d.h;
      res_o.minute = clk_d.m;
      res_o.second = clk_d.s;
    end
    res_o.day       = cal_d.d;
    res_o.month     = cal_d.mo;
    res_o.year      = cal_d.y;
    res_o.alarm_hit = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q     <= '{h: 4'd12, m: 6'd35, s: 6'd50};
      pm_q      <= 1'b0;
      cal_q     <= '{d: 5'd17, mo: 4'd12, y: 7'd21};
      al_time_q <= '{h: 4'd12, m: 6'd36, s: 6'd0};
      al_date_q <= '{d: 5'd17, mo: 4'd12, y: 7'd21};
      sw_q      <= '0;
      wm_q      <= WM_RESET;
    end else begin
      clk_q     <= clk_d;
      pm_q      <= pm_d;
      cal_q     <= cal_d;
      al_time_q <= al_time_d;
      al_date_q <= al_date_d;
      sw_q      <= sw_d;
      wm_q      <= wm_d;
    end
  end

endmodule

// ===== design/rtc_calendar_alarm_stopwatch.sv =====
// Top level: 12-hour clock with calendar, alarm and stopwatch behind valid/ready channels.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | action_i, edit_field_i
//  out     | out       | out_valid_o/out_ready_i | shown_*_o, alarm_hit_o
//
//  One item per cycle sustained while the output does not stall. A transfer on
//  the input lands in the input register; the update logic then applies it to the
//  state and loads the result register, which raises out_valid_o.
//  Reset puts the clock at 12:35:50 AM on day 17, month 12, year 21 and leaves
//  both stages empty. A stall on the output holds the result register and then
//  the input register; in_ready_o drops only when both are full.
module rtc_calendar_alarm_stopwatch (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rtca_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rtca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      action_i,
  input  logic [1:0]                      edit_field_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [3:0]                      shown_hour_o,
  output logic [5:0]                      shown_minute_o,
  output logic [5:0]                      shown_second_o,
  output logic [4:0]                      shown_day_o,
  output logic [3:0]                      shown_month_o,
  output logic [6:0]                      shown_year_o,
  output logic                            alarm_hit_o
);
  import rtca_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;
  action_e    act_q;
  logic [1:0] fld_q;
  logic       in_vld_q, in_vld_d;
  logic       out_vld_q, out_vld_d;
  logic       advance;   // result register can take a new value
  logic       step;      // apply the held item this cycle
  logic       in_xfer;

  // Configuration is always taken; writes must only happen while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  rtca_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  assign advance    = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer)   in_vld_d = 1'b1;
    else if (step) in_vld_d = 1'b0;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step)             out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the item on its transfer; hold it while the output stalls.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q <= action_e'(action_i);
      fld_q <= edit_field_i;
    end
  end

  rtca_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .action_i (act_q),
    .field_i  (fld_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Load the result as the item is applied; hold it until the output transfer.
  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign out_valid_o    = out_vld_q;
  assign shown_hour_o   = res_q.hour;
  assign shown_minute_o = res_q.minute;
  assign shown_second_o = res_q.second;
  assign shown_day_o    = res_q.day;
  assign shown_month_o  = res_q.month;
  assign shown_year_o   = res_q.year;
  assign alarm_hit_o    = res_q.alarm_hit;

endmodule

// ===== design/rtca_chk.sv =====
// Port-level checker for the clock block, bound to the top level.
`include "rtc_calendar_alarm_stopwatch_defines.svh"

module rtca_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] shown_hour_o,
  input logic [5:0] shown_minute_o,
  input logic [5:0] shown_second_o,
  input logic [4:0] shown_day_o,
  input logic [3:0] shown_month_o,
  input logic [6:0] shown_year_o,
  input logic       alarm_hit_o
);

  logic [32:0] out_bus;
  logic        stall;
  logic        time_ok;
  logic        date_ok;

  assign out_bus = {shown_hour_o, shown_minute_o, shown_second_o, shown_day_o,
                    shown_month_o, shown_year_o, alarm_hit_o};
  assign stall   = out_valid_o && !out_ready_i;
  assign time_ok = (shown_hour_o <= 4'd12) && (shown_minute_o <= 6'd59) &&
                   (shown_second_o <= 6'd59);
  assign date_ok = (shown_day_o != 5'd0) && (shown_month_o != 4'd0) &&
                   (shown_month_o <= 4'd12) && (shown_year_o <= 7'd99);

  `RTCA_ASSERT_NEXT(a_out_valid_holds, stall, out_valid_o, "out_valid_o dropped before transfer")
  `RTCA_ASSERT_NEXT(a_out_data_holds, stall, $stable(out_bus), "result changed while stalled")
  `RTCA_ASSERT_NOW(a_time_range, out_valid_o, time_ok, "shown time out of range")
  `RTCA_ASSERT_NOW(a_date_range, out_valid_o, date_ok, "shown date out of range")

endmodule

bind rtc_calendar_alarm_stopwatch rtca_chk u_rtca_chk (.*);
